FILE: hw/rtl/lane_position_estimator_core_assert.svh
// Assertion macros shared by the port checker.
`ifndef LANE_POSITION_ESTIMATOR_CORE_ASSERT_SVH
`define LANE_POSITION_ESTIMATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define LPE_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LPE_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lpe_pkg.sv
// Shared types, constants and helpers of the lane position estimator.
package lpe_pkg;

  localparam int POS_W      = 12;
  localparam int COUNT_W    = 9;
  localparam int SUM_W      = 20;
  localparam int SLOPE_W    = 25;
  localparam int SSUM_W     = 33;
  localparam int HSUM_W     = 23;
  localparam int HK_W       = 11;
  localparam int WGT_W      = 9;
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_DEN_W  = 34;
  localparam int DIV_CNT_W  = 6;
  localparam int SAT_LIM    = 2048;

  localparam logic [9:0] GATE_RESET = 10'd70;

  localparam logic [1:0] ACT_SEG   = 2'd0;
  localparam logic [1:0] ACT_LAST  = 2'd1;
  localparam logic [1:0] ACT_EMPTY = 2'd2;

  localparam logic [DIV_CNT_W-1:0] SLOPE_ITERS = 6'd24;
  localparam logic [DIV_CNT_W-1:0] MEAN_ITERS  = 6'd32;
  localparam logic [DIV_CNT_W-1:0] POS_ITERS   = 6'd46;
  localparam logic [DIV_CNT_W-1:0] HIST_ITERS  = 6'd22;

  localparam logic signed [POS_W-1:0] POS_MAXV = 12'sd2047;
  localparam logic signed [POS_W-1:0] POS_MINV = -12'sd2048;

  typedef enum logic [1:0] {
    CMD_SEG,
    CMD_LAST,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        flat;
    logic        neg;
    logic [9:0]  adx;
    logic [7:0]  ady;
    logic [9:0]  sx;
    logic [9:0]  ex;
    logic [10:0] xpair;
    logic [8:0]  ysum;
  } cmd_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLOPE,
    ST_GATE,
    ST_POS,
    ST_MDIV,
    ST_MUL,
    ST_NUM,
    ST_PSTART,
    ST_PDIV,
    ST_HIST,
    ST_HSUM,
    ST_HSTART,
    ST_HDIV,
    ST_SIDE,
    ST_EMIT
  } back_state_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic [DIV_NUM_W-1:0] mag,
                                                      input logic neg);
    logic [DIV_NUM_W-1:0] negm;
    negm = -mag;
    if (neg) begin
      sat_pos = (mag > DIV_NUM_W'(SAT_LIM)) ? POS_MINV : $signed(negm[POS_W-1:0]);
    end else begin
      sat_pos = (mag > DIV_NUM_W'(SAT_LIM - 1)) ? POS_MAXV : $signed(mag[POS_W-1:0]);
    end
  endfunction

endpackage

FILE: hw/rtl/lane_position_estimator_core.sv
// Lane position estimator: top level.
// Segments queue through a two-entry command queue into a sequential back end
// built round one shared serial divider (one quotient bit per cycle). A
// segment that is not flat passes fetch, the slope division, its done strobe
// and the gate; a flat segment is taken at fetch alone. A frame end adds, per
// side, up to three divisions (mean, position, history) plus a summing pass
// over the HISTORY_DEPTH history entries. The front accepts requests while the
// back end works and while a result waits on the output register, until two
// requests sit in the queue; full is then high until the back end takes one.
module lane_position_estimator_core #(
  parameter int IMAGE_WIDTH   = 640,
  parameter int BAND_HEIGHT   = 64,
  parameter int HISTORY_DEPTH = 10,
  parameter int MAX_SEGMENTS  = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        action,
  input  logic [9:0]                        start_x,
  input  logic [7:0]                        start_y,
  input  logic [9:0]                        end_x,
  input  logic [7:0]                        end_y,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [lpe_pkg::POS_W-1:0]  left_position,
  output logic signed [lpe_pkg::POS_W-1:0]  right_position,
  output logic signed [lpe_pkg::POS_W-1:0]  smoothed_left,
  output logic signed [lpe_pkg::POS_W-1:0]  smoothed_right,
  input  logic                              config_write,
  input  logic [9:0]                        config_data
);
  import lpe_pkg::*;

  logic     [9:0] gate;
  logic     q_full, q_empty, q_push, q_pop;
  cmd_t     wr_cmd, rd_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate <= GATE_RESET;
    end else if (config_write) begin
      gate <= config_data;
    end
  end

  lpe_front u_front (
    .push    (push),
    .full    (full),
    .action  (action),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (wr_cmd)
  );

  lpe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (wr_cmd),
    .rd      (q_pop),
    .rd_data (rd_cmd),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  lpe_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lpe_back #(
    .IMAGE_WIDTH   (IMAGE_WIDTH),
    .BAND_HEIGHT   (BAND_HEIGHT),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_SEGMENTS  (MAX_SEGMENTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .gate           (gate),
    .q_empty        (q_empty),
    .q_data         (rd_cmd),
    .q_pop          (q_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .pop            (pop),
    .empty          (empty),
    .left_position  (left_position),
    .right_position (right_position),
    .smoothed_left  (smoothed_left),
    .smoothed_right (smoothed_right)
  );

endmodule

FILE: hw/rtl/lpe_front.sv
// Front end: accepts requests and classifies them into decoded commands.
module lpe_front (
  input  logic          push,
  output logic          full,
  input  logic [1:0]    action,
  input  logic [9:0]    start_x,
  input  logic [7:0]    start_y,
  input  logic [9:0]    end_x,
  input  logic [7:0]    end_y,
  input  logic          q_full,
  output logic          q_push,
  output lpe_pkg::cmd_t q_data
);
  import lpe_pkg::*;

  logic signed [10:0] dx;
  logic signed [8:0]  dy;
  logic [10:0]        ndx;
  logic [8:0]         ndy;
  logic               known;

  always_comb begin
    dx  = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    dy  = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    ndx = -dx;
    ndy = -dy;
    known = 1'b1;
    q_data.kind = CMD_SEG;
    case (action)
      ACT_SEG:   q_data.kind = CMD_SEG;
      ACT_LAST:  q_data.kind = CMD_LAST;
      ACT_EMPTY: q_data.kind = CMD_NONE;
      default:   known = 1'b0;
    endcase
    q_data.flat  = (dx == 11'sd0) || (dy == 9'sd0);
    q_data.neg   = dx[10] ^ dy[8];
    q_data.adx   = dx[10] ? ndx[9:0] : dx[9:0];
    q_data.ady   = dy[8] ? ndy[7:0] : dy[7:0];
    q_data.sx    = start_x;
    q_data.ex    = end_x;
    q_data.xpair = {1'b0, start_x} + {1'b0, end_x};
    q_data.ysum  = {1'b0, start_y} + {1'b0, end_y};
  end

  assign full   = q_full;
  assign q_push = push && !q_full && known;

endmodule

FILE: hw/rtl/lpe_queue.sv
// Two-entry command queue between front and back end.
module lpe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  lpe_pkg::cmd_t wr_data,
  input  logic          rd,
  output lpe_pkg::cmd_t rd_data,
  output logic          q_full,
  output logic          q_empty
);
  import lpe_pkg::*;

  cmd_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        mem[wptr] <= wr_data;
        wptr      <= !wptr;
      end
      if (rd) begin
        rptr <= !rptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign rd_data = mem[rptr];
  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);

endmodule

FILE: hw/rtl/lpe_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lpe_divider (
  input  logic              clk,
  input  logic              rst,
  input  lpe_pkg::div_req_t req,
  output lpe_pkg::div_rsp_t rsp
);
  import lpe_pkg::*;

  logic [DIV_NUM_W-1:0] num_sr;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  always_comb begin
    trial = {rem, num_sr[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num_sr <= req.num;
        den_r  <= req.den;
        rem    <= '0;
        quo    <= '0;
        cnt    <= req.iters;
        busy   <= 1'b1;
      end else if (busy) begin
        num_sr <= {num_sr[DIV_NUM_W-2:0], 1'b0};
        rem    <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        quo    <= {quo[DIV_NUM_W-2:0], ge};
        cnt    <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

FILE: hw/rtl/lpe_back.sv
// Back end: slope, gating, per-frame sums, positions and history smoothing.
module lpe_back #(
  parameter int IMAGE_WIDTH   = 640,
  parameter int BAND_HEIGHT   = 64,
  parameter int HISTORY_DEPTH = 10,
  parameter int MAX_SEGMENTS  = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [9:0]                        gate,
  input  logic                              q_empty,
  input  lpe_pkg::cmd_t                     q_data,
  output logic                              q_pop,
  output lpe_pkg::div_req_t                 div_req,
  input  lpe_pkg::div_rsp_t                 div_rsp,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [lpe_pkg::POS_W-1:0]  left_position,
  output logic signed [lpe_pkg::POS_W-1:0]  right_position,
  output logic signed [lpe_pkg::POS_W-1:0]  smoothed_left,
  output logic signed [lpe_pkg::POS_W-1:0]  smoothed_right
);
  import lpe_pkg::*;

  localparam int HIDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HALF_W = IMAGE_WIDTH / 2;
  localparam int PROBE2 = 2 * (BAND_HEIGHT / 2);
  localparam logic signed [POS_W-1:0] WIDTH_POS = POS_W'(IMAGE_WIDTH);

  back_state_t state, state_next;
  cmd_t        cmd_r;
  logic        side;

  logic [COUNT_W-1:0]       lc, rc;
  logic [SUM_W-1:0]         lxs, lys, rxs, rys;
  logic signed [SSUM_W-1:0] lss, rss;
  logic signed [POS_W-1:0]  lm, rm;
  logic signed [POS_W-1:0]  hist_l [HISTORY_DEPTH];
  logic signed [POS_W-1:0]  hist_r [HISTORY_DEPTH];

  logic signed [SLOPE_W-1:0] m_r;
  logic                      m_neg;
  logic signed [45:0]        xm;
  logic [DIV_DEN_W-1:0]      den_mag;
  logic [45:0]               num_mag;
  logic                      quo_neg;
  logic signed [POS_W-1:0]   pos_l, pos_r;
  logic [HIDX_W-1:0]         hidx;
  logic [WGT_W-1:0]          wgt;
  logic signed [HSUM_W-1:0]  hsum;
  logic [HK_W-1:0]           hk;
  logic                      out_valid;
  logic signed [POS_W-1:0]   out_lp, out_rp, out_sl, out_sr;

  logic [COUNT_W-1:0]        sel_n;
  logic [SUM_W-1:0]          sel_x, sel_y;
  logic signed [SSUM_W-1:0]  sel_s;
  logic signed [POS_W-1:0]   sel_empty, sel_pos, hrd;
  logic                      hvalid;
  logic [31:0]               sabs;
  logic [SSUM_W-1:0]         sneg;
  logic [23:0]               m_abs;
  logic [SLOPE_W-1:0]        mneg;
  logic signed [20:0]        t;
  logic signed [45:0]        num_s;
  logic [45:0]               num_neg;
  logic [HSUM_W-1:0]         hsum_neg;
  logic [21:0]               hsum_abs;
  logic signed [SLOPE_W-1:0] slope_s;
  logic signed [13:0]        d_l, d_r, nd_l, nd_r;
  logic [13:0]               gate2;
  logic                      left_hit, right_hit;
  logic signed [HSUM_W-1:0]  wgt_s;

  always_comb begin
    sel_n     = side ? rc : lc;
    sel_x     = side ? rxs : lxs;
    sel_y     = side ? rys : lys;
    sel_s     = side ? rss : lss;
    sel_empty = side ? WIDTH_POS : '0;
    sel_pos   = side ? pos_r : pos_l;
    hrd       = side ? hist_r[hidx] : hist_l[hidx];
    hvalid    = side ? (hrd < WIDTH_POS) : (hrd > 12'sd0);
    sneg      = -sel_s;
    sabs      = sel_s[SSUM_W-1] ? sneg[31:0] : sel_s[31:0];
    mneg      = -m_r;
    m_abs     = m_neg ? mneg[23:0] : m_r[23:0];
    t         = $signed(21'(PROBE2) * 21'(sel_n)) - $signed({1'b0, sel_y});
    num_s     = (46'(t) <<< 16) + xm;
    num_neg   = -num_s;
    hsum_neg  = -hsum;
    hsum_abs  = hsum[HSUM_W-1] ? hsum_neg[21:0] : hsum[21:0];
    slope_s   = cmd_r.neg ? -$signed({1'b0, div_rsp.quo[23:0]})
                          : $signed({1'b0, div_rsp.quo[23:0]});
    gate2     = {3'b0, gate, 1'b0};
    d_l       = {lm[POS_W-1], lm, 1'b0} - $signed({3'b0, cmd_r.xpair});
    d_r       = {rm[POS_W-1], rm, 1'b0} - $signed({3'b0, cmd_r.xpair});
    nd_l      = -d_l;
    nd_r      = -d_r;
    left_hit  = cmd_r.neg && ({1'b0, cmd_r.ex} < 11'(HALF_W)) &&
                (((d_l[13] ? nd_l : d_l) < gate2) || (lm == 12'sd0));
    right_hit = !cmd_r.neg && ({1'b0, cmd_r.sx} > 11'(HALF_W)) &&
                (((d_r[13] ? nd_r : d_r) < gate2) || (rm == WIDTH_POS));
    wgt_s     = $signed(HSUM_W'(wgt));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_req    = '0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.kind == CMD_NONE) begin
            state_next = ST_EMIT;
          end else if (q_data.flat) begin
            state_next = (q_data.kind == CMD_LAST) ? ST_POS : ST_IDLE;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = {q_data.ady, 40'b0};
            div_req.den   = DIV_DEN_W'(q_data.adx);
            div_req.iters = SLOPE_ITERS;
            state_next    = ST_SLOPE;
          end
        end
      end
      ST_SLOPE: if (div_rsp.done) state_next = ST_GATE;
      ST_GATE: state_next = (cmd_r.kind == CMD_LAST) ? ST_POS : ST_IDLE;
      ST_POS: begin
        if (sel_n == '0) begin
          state_next = ST_HIST;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {sabs, 16'b0};
          div_req.den   = DIV_DEN_W'(sel_n);
          div_req.iters = MEAN_ITERS;
          state_next    = ST_MDIV;
        end
      end
      ST_MDIV: if (div_rsp.done) state_next = ST_MUL;
      ST_MUL: state_next = (m_r == '0) ? ST_HIST : ST_NUM;
      ST_NUM: state_next = ST_PSTART;
      ST_PSTART: begin
        div_req.start = 1'b1;
        div_req.num   = {num_mag, 2'b0};
        div_req.den   = den_mag;
        div_req.iters = POS_ITERS;
        state_next    = ST_PDIV;
      end
      ST_PDIV: if (div_rsp.done) state_next = ST_HIST;
      ST_HIST: state_next = (sel_pos == sel_empty) ? ST_SIDE : ST_HSUM;
      ST_HSUM: if (hidx == HIDX_W'(HISTORY_DEPTH - 1)) state_next = ST_HSTART;
      ST_HSTART: begin
        if (hk == '0) begin
          state_next = ST_SIDE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {hsum_abs, 26'b0};
          div_req.den   = DIV_DEN_W'(hk);
          div_req.iters = HIST_ITERS;
          state_next    = ST_HDIV;
        end
      end
      ST_HDIV: if (div_rsp.done) state_next = ST_SIDE;
      ST_SIDE: state_next = side ? ST_EMIT : ST_POS;
      ST_EMIT: if (!out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lc <= '0; rc <= '0;
      lxs <= '0; lys <= '0; rxs <= '0; rys <= '0;
      lss <= '0; rss <= '0;
      lm <= '0;
      rm <= WIDTH_POS;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_l[i] <= '0;
        hist_r[i] <= WIDTH_POS;
      end
      out_valid <= 1'b0;
      side      <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cmd_r <= q_data;
            side  <= 1'b0;
            if (q_data.kind == CMD_NONE) begin
              pos_l <= '0;
              pos_r <= WIDTH_POS;
            end
          end
        end
        ST_GATE: begin
          if (left_hit) begin
            if (lc < COUNT_W'(MAX_SEGMENTS)) begin
              lc  <= lc + 1'b1;
              lxs <= lxs + SUM_W'(cmd_r.xpair);
              lys <= lys + SUM_W'(cmd_r.ysum);
              lss <= lss + SSUM_W'(slope_s);
            end
          end else if (right_hit && (rc < COUNT_W'(MAX_SEGMENTS))) begin
            rc  <= rc + 1'b1;
            rxs <= rxs + SUM_W'(cmd_r.xpair);
            rys <= rys + SUM_W'(cmd_r.ysum);
            rss <= rss + SSUM_W'(slope_s);
          end
        end
        ST_POS: begin
          if (sel_n == '0) begin
            if (side) pos_r <= sel_empty; else pos_l <= sel_empty;
          end
        end
        ST_MDIV: begin
          if (div_rsp.done) begin
            m_neg <= sel_s[SSUM_W-1];
            m_r   <= sel_s[SSUM_W-1] ? -$signed({1'b0, div_rsp.quo[23:0]})
                                     : $signed({1'b0, div_rsp.quo[23:0]});
          end
        end
        ST_MUL: begin
          if (m_r == '0) begin
            if (side) pos_r <= sel_empty; else pos_l <= sel_empty;
          end else begin
            xm      <= 46'($signed({1'b0, sel_x})) * 46'(m_r);
            den_mag <= DIV_DEN_W'({sel_n, 1'b0}) * DIV_DEN_W'(m_abs);
          end
        end
        ST_NUM: begin
          num_mag <= num_s[45] ? num_neg : num_s;
          quo_neg <= num_s[45] ^ m_neg;
        end
        ST_PDIV: begin
          if (div_rsp.done) begin
            if (side) pos_r <= sat_pos(div_rsp.quo, quo_neg);
            else      pos_l <= sat_pos(div_rsp.quo, quo_neg);
          end
        end
        ST_HIST: begin
          if (sel_pos == sel_empty) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
              if (side) hist_r[i] <= sel_empty; else hist_l[i] <= sel_empty;
            end
            if (side) rm <= sel_empty; else lm <= sel_empty;
          end else begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
              if (side) hist_r[i] <= hist_r[i+1]; else hist_l[i] <= hist_l[i+1];
            end
            if (side) hist_r[HISTORY_DEPTH-1] <= sel_pos;
            else      hist_l[HISTORY_DEPTH-1] <= sel_pos;
          end
          hidx <= '0;
          wgt  <= WGT_W'(1);
          hsum <= '0;
          hk   <= '0;
        end
        ST_HSUM: begin
          if (hvalid) begin
            hsum <= hsum + HSUM_W'(hrd) * wgt_s;
            hk   <= hk + HK_W'(wgt);
          end
          wgt  <= wgt + WGT_W'({hidx, 1'b0}) + WGT_W'(3);
          hidx <= hidx + 1'b1;
        end
        ST_HSTART: begin
          if (hk == '0) begin
            if (side) rm <= sel_empty; else lm <= sel_empty;
          end
        end
        ST_HDIV: begin
          if (div_rsp.done) begin
            if (side) rm <= sat_pos(div_rsp.quo, hsum[HSUM_W-1]);
            else      lm <= sat_pos(div_rsp.quo, hsum[HSUM_W-1]);
          end
        end
        ST_SIDE: side <= 1'b1;
        ST_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_lp    <= pos_l;
            out_rp    <= pos_r;
            out_sl    <= lm;
            out_sr    <= rm;
            lc <= '0; rc <= '0;
            lxs <= '0; lys <= '0; rxs <= '0; rys <= '0;
            lss <= '0; rss <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign empty          = !out_valid;
  assign left_position  = out_lp;
  assign right_position = out_rp;
  assign smoothed_left  = out_sl;
  assign smoothed_right = out_sr;

endmodule

FILE: hw/rtl/lpe_port_check.sv
// Port-level checks for the lane position estimator, bound to the top level.
`include "lane_position_estimator_core_assert.svh"

module lpe_port_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic signed [lpe_pkg::POS_W-1:0]  left_position,
  input logic signed [lpe_pkg::POS_W-1:0]  right_position,
  input logic signed [lpe_pkg::POS_W-1:0]  smoothed_left,
  input logic signed [lpe_pkg::POS_W-1:0]  smoothed_right
);
  import lpe_pkg::*;

  `LPE_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, empty && !full, "not idle after reset")

  `LPE_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(left_position) && $stable(right_position) && $stable(smoothed_left) && $stable(smoothed_right), "waiting result changed")

  `LPE_ASSERT_NOW(a_left_mean_sign, clk, rst, !empty, !smoothed_left[POS_W-1], "left mean negative")

endmodule

bind lane_position_estimator_core lpe_port_check u_port_check (.*);
